[design/trnat_pkg.sv]
// trnat_pkg: shared types and constants of the redirect / nat table block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package trnat_pkg;

  localparam logic [15:0] IPV4_TYPE = 16'h0800;
  localparam logic [7:0]  TCP_PROTO = 8'd6;
  localparam logic [3:0]  MIN_IHL   = 4'd5;
  localparam logic [16:0] ETH_BYTES = 17'd14;
  localparam logic [16:0] TCP_BYTES = 17'd20;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROXY_ADDR = 2'd0,
    CFG_PROXY_PORT = 2'd1,
    CFG_PORT_PLAIN = 2'd2,
    CFG_PORT_TLS   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic        mode;
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [3:0]  header_words;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] ip_checksum_in;
    logic [15:0] tcp_checksum_in;
  } hdr_t;

  typedef struct packed {
    logic        rewritten;
    logic [31:0] new_addr;
    logic [15:0] new_port;
    logic [15:0] ip_checksum_out;
    logic [15:0] tcp_checksum_out;
    logic        evicted;
  } res_t;

  // one ones-complement add of a 16 bit term with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage
`default_nettype wire

[design/trnat_ram.sv]
// trnat_ram: generic single port ram, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module trnat_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

[design/trnat_csum.sv]
// trnat_csum: shared ones-complement accumulator, one 16 bit term per cycle
// depends on trnat_pkg
`timescale 1ns / 1ps
`default_nettype none
module trnat_csum
  import trnat_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire logic [15:0] init_i,
  input  wire logic        add_i,
  input  wire logic [15:0] term_i,
  output logic      [15:0] acc_o
);
  logic [15:0] acc_q, acc_d;
  always_comb begin
    acc_d = acc_q;
    if (load_i) acc_d = init_i;
    else if (add_i) acc_d = oc_add(acc_q, term_i);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) acc_q <= '0;
    else acc_q <= acc_d;
  end
  assign acc_o = acc_q;
endmodule
`default_nettype wire

[design/tcp_redirect_nat_table_top.sv]
// tcp_redirect_nat_table_top: transparent proxy redirect with connection table
// depends on trnat_pkg, trnat_ram, trnat_csum
`timescale 1ns / 1ps
`default_nettype none
// usage
// a header word is taken when start is high and busy low. busy stays
// high until the result word is shown on res_o with done_o for one cycle;
// the receiver cannot stall and must take it then.
// the item runs on a small sequencer: a read state addresses the set, a decide
// state picks the way and, on a rewrite, writes back all ways of the set, then the
// checksums are folded by one shared ones-complement adder, one 16 bit term a cycle
// (ip: load then 4 terms, tcp: load, 4 address terms then 2 port terms).
// busy drops the cycle after done_o, so one item is handled at a time; a word
// that is not looked up and an egress miss skip the checksum passes.
// the table is one ram word per set holding all ways, TABLE_SETS words;
// TABLE_SETS must be a power of two; the block itself does not enforce it.
// after reset a clearing pass writes every set (valid off, ages in way
// order), one set per cycle, with busy high until the last set is written.
// configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) are taken any time,
// but only meant while idle; unknown indexes are ignored.
module tcp_redirect_nat_table_top
  import trnat_pkg::*;
#(
  parameter int unsigned TABLE_SETS = 256,
  parameter int unsigned TABLE_WAYS = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire hdr_t                  hdr_i,
  output logic                       done_o,
  output res_t                       res_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);
  localparam int unsigned SetW = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;
  localparam int unsigned WayW = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
  localparam int unsigned AgeW = WayW;
  localparam int unsigned EntW = 1 + 32 + 16 + 32 + 16 + AgeW;
  localparam int unsigned RowW = EntW * TABLE_WAYS;

  typedef struct packed {
    logic            valid;
    logic [31:0]     caddr;
    logic [15:0]     cport;
    logic [31:0]     oaddr;
    logic [15:0]     oport;
    logic [AgeW-1:0] age;
  } ent_t;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_DECIDE = 7'b0001000,
    ST_IPSUM = 7'b0010000,
    ST_TCPSUM = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [31:0] proxy_addr_q;
  logic [15:0] proxy_port_q, port_plain_q, port_tls_q;
  hdr_t hdr_q;
  logic [SetW-1:0] clr_q;
  logic [2:0] step_q, step_d;
  logic rew_q, evict_q;
  logic [31:0] naddr_q;
  logic [15:0] nport_q, ipc_q;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proxy_addr_q <= '0;
      proxy_port_q <= '0;
      port_plain_q <= 16'd80;
      port_tls_q   <= 16'd443;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PROXY_ADDR: proxy_addr_q <= cfg_data_i;
        CFG_PROXY_PORT: proxy_port_q <= cfg_data_i[15:0];
        CFG_PORT_PLAIN: port_plain_q <= cfg_data_i[15:0];
        CFG_PORT_TLS:   port_tls_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // qualification and key of the held word
  logic ok, ing_act, lookup;
  logic [16:0] need_len;
  logic [31:0] key_addr, oaddr_w;
  logic [15:0] key_port, oport_w, fold;
  logic [SetW-1:0] set_idx;
  always_comb begin
    need_len = ETH_BYTES + TCP_BYTES + {11'd0, hdr_q.header_words, 2'b00};
    ok = hdr_q.ether_type == IPV4_TYPE && hdr_q.ip_protocol == TCP_PROTO &&
         hdr_q.header_words >= MIN_IHL && {1'b0, hdr_q.frame_length} >= need_len;
    ing_act = (hdr_q.dport == port_plain_q || hdr_q.dport == port_tls_q) &&
              proxy_addr_q != '0;
    lookup = ok && (hdr_q.mode || ing_act);
    key_addr = hdr_q.mode ? hdr_q.dst_addr : hdr_q.src_addr;
    key_port = hdr_q.mode ? hdr_q.dport : hdr_q.sport;
    oaddr_w  = hdr_q.mode ? hdr_q.src_addr : hdr_q.dst_addr;
    oport_w  = hdr_q.mode ? hdr_q.sport : hdr_q.dport;
    fold = key_addr[31:16] ^ key_addr[15:0] ^ key_port;
    set_idx = SetW'(fold & 16'(TABLE_SETS - 1));
  end

  // table ram
  logic ram_we;
  logic [SetW-1:0] ram_addr;
  logic [RowW-1:0] ram_wdata, ram_rdata, clr_row;
  trnat_ram #(.Width(RowW), .Depth(TABLE_SETS)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  always_comb begin
    ent_t e;
    clr_row = '0;
    for (int w = 0; w < TABLE_WAYS; w++) begin
      e = '0;
      e.age = AgeW'(w);
      clr_row[w*EntW +: EntW] = e;
    end
  end

  // way selection and lru update
  ent_t row_ent [TABLE_WAYS];
  logic hit, has_free, dec_evict;
  logic [WayW-1:0] hit_way, free_way, old_way, sel_way;
  logic [AgeW-1:0] sel_age;
  logic [RowW-1:0] new_row;
  always_comb begin
    ent_t e;
    hit = 1'b0; has_free = 1'b0;
    hit_way = '0; free_way = '0; old_way = '0;
    for (int w = 0; w < TABLE_WAYS; w++) row_ent[w] = ram_rdata[w*EntW +: EntW];
    for (int w = TABLE_WAYS-1; w >= 0; w--) begin
      if (row_ent[w].valid && row_ent[w].caddr == key_addr &&
          row_ent[w].cport == key_port) begin
        hit = 1'b1; hit_way = WayW'(w);
      end
      if (!row_ent[w].valid) begin
        has_free = 1'b1; free_way = WayW'(w);
      end
    end
    for (int w = 1; w < TABLE_WAYS; w++)
      if (row_ent[w].age > row_ent[old_way].age) old_way = WayW'(w);
    dec_evict = 1'b0;
    if (hdr_q.mode || hit) sel_way = hit_way;
    else if (has_free) sel_way = free_way;
    else begin
      sel_way = old_way; dec_evict = 1'b1;
    end
    sel_age = row_ent[sel_way].age;
    new_row = '0;
    for (int w = 0; w < TABLE_WAYS; w++) begin
      e = row_ent[w];
      if (WayW'(w) == sel_way) begin
        e.age = '0;
        if (!hdr_q.mode) begin
          e.valid = 1'b1;
          e.caddr = hdr_q.src_addr;
          e.cport = hdr_q.sport;
          e.oaddr = hdr_q.dst_addr;
          e.oport = hdr_q.dport;
        end
      end else if (e.age < sel_age) begin
        e.age = e.age + AgeW'(1);
      end
      new_row[w*EntW +: EntW] = e;
    end
  end

  // checksum terms: ~from high, ~from low, to high, to low, then ports
  // the tcp pass loads at its step 0, so its terms run one step behind
  logic [2:0] tstep;
  logic [15:0] term;
  always_comb begin
    tstep = (state_q == ST_TCPSUM) ? step_q - 3'd1 : step_q;
    unique case (tstep[1:0])
      2'd0: term = ~oaddr_w[31:16];
      2'd1: term = ~oaddr_w[15:0];
      2'd2: term = naddr_q[31:16];
      default: term = naddr_q[15:0];
    endcase
    if (state_q == ST_TCPSUM && tstep[2]) term = tstep[0] ? nport_q : ~oport_w;
  end

  logic cs_load, cs_add;
  logic [15:0] cs_init, acc;
  trnat_csum u_csum (
    .clk_i, .rst_ni, .load_i(cs_load), .init_i(cs_init), .add_i(cs_add),
    .term_i(term), .acc_o(acc)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d = step_q;
    ram_we = 1'b0;
    ram_addr = set_idx;
    ram_wdata = new_row;
    cs_load = 1'b0; cs_add = 1'b0;
    cs_init = ~hdr_q.ip_checksum_in;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1; ram_addr = clr_q; ram_wdata = clr_row;
        if (clr_q == SetW'(TABLE_SETS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: if (start) state_d = ST_READ;
      ST_READ: state_d = lookup ? ST_DECIDE : ST_DONE;
      ST_DECIDE: begin
        if (hdr_q.mode == 1'b0 || hit) begin
          ram_we = 1'b1;
          state_d = ST_IPSUM;
          cs_load = 1'b1;
          step_d = '0;
        end else state_d = ST_DONE;
      end
      ST_IPSUM: begin
        cs_add = 1'b1;
        step_d = step_q + 3'd1;
        if (step_q == 3'd3) begin
          state_d = ST_TCPSUM; step_d = '0;
        end
      end
      ST_TCPSUM: begin
        if (step_q == 3'd0) begin
          cs_load = 1'b1; cs_init = ~hdr_q.tcp_checksum_in;
          step_d = 3'd1;
        end else begin
          cs_add = 1'b1;
          step_d = step_q + 3'd1;
          if (step_q == 3'd6) state_d = ST_DONE;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      step_q <= '0;
      rew_q <= 1'b0;
      evict_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + SetW'(1);
      if (state_q == ST_IDLE && start) begin
        rew_q <= 1'b0; evict_q <= 1'b0;
      end
      if (state_q == ST_DECIDE && (hdr_q.mode == 1'b0 || hit)) begin
        rew_q <= 1'b1;
        evict_q <= !hdr_q.mode && !hit && dec_evict;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) hdr_q <= hdr_i;
    if (state_q == ST_READ) begin
      naddr_q <= oaddr_w; nport_q <= oport_w;
      ipc_q <= hdr_q.ip_checksum_in;
    end
    if (state_q == ST_DECIDE && (hdr_q.mode == 1'b0 || hit)) begin
      naddr_q <= hdr_q.mode ? row_ent[hit_way].oaddr : proxy_addr_q;
      nport_q <= hdr_q.mode ? row_ent[hit_way].oport : proxy_port_q;
    end
    if (state_q == ST_TCPSUM && step_q == 3'd0) ipc_q <= ~acc;
  end

  logic [15:0] tcp_out;
  assign tcp_out = rew_q ? ~acc : hdr_q.tcp_checksum_in;

  assign busy = state_q != ST_IDLE;
  assign done_o = state_q == ST_DONE;
  always_comb begin
    res_o.rewritten = rew_q;
    res_o.new_addr = naddr_q;
    res_o.new_port = nport_q;
    res_o.ip_checksum_out = ipc_q;
    res_o.tcp_checksum_out = tcp_out;
    res_o.evicted = evict_q;
  end
endmodule
`default_nettype wire

[design/trnat_checker.sv]
// trnat_checker: port level checks of the redirect block
// depends on trnat_pkg, binds to tcp_redirect_nat_table_top
`timescale 1ns / 1ps
`default_nettype none
module trnat_checker
  import trnat_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o,
  input wire res_t res_o
);
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held two cycles");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("done while idle");
  a_idle_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("busy after done");
  a_evict_rew: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.evicted |-> res_o.rewritten) else $error("evict without rewrite");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted word did not start");
endmodule

bind tcp_redirect_nat_table_top trnat_checker u_trnat_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .res_o
);
`default_nettype wire
